@@ src/encoder_velocity_pid_macros.svh @@
// Assertion macros used by the encoder velocity PID top-level module.
`ifndef ENCODER_VELOCITY_PID_MACROS_SVH
`define ENCODER_VELOCITY_PID_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define EVP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// An implication checked in the same cycle, outside reset.
`define EVP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ src/evp_pkg.sv @@
// Shared widths, register indexes and types of the encoder velocity PID.
package evp_pkg;

    localparam int CNT_W      = 32;
    localparam int TGT_W      = 16;
    localparam int RATE_W     = 32;
    localparam int DRV_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int ILIM_W     = 20;
    localparam int DLIM_W     = 15;
    localparam int INT_W      = 22;
    localparam int ERR_W      = RATE_W + 1;
    localparam int PROD_W     = GAIN_W + 1 + ERR_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int DVD_W      = SUM_W - 1;
    localparam int DSUM_W     = SUM_W + 1;
    localparam int ACC_W      = PROD_W + 1;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [GAIN_W-1:0] KP_RESET   = 16'd30;
    localparam logic [GAIN_W-1:0] KD_RESET   = 16'd7;
    localparam logic [GAIN_W-1:0] KI_RESET   = 16'd25;
    localparam logic [GAIN_W-1:0] DIV_RESET  = 16'd600;
    localparam logic [ILIM_W-1:0] ILIM_RESET = 20'd100;
    localparam logic [DLIM_W-1:0] DLIM_RESET = 15'd255;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_KP   = 3'd0,
        CFG_KD   = 3'd1,
        CFG_KI   = 3'd2,
        CFG_DIV  = 3'd3,
        CFG_ILIM = 3'd4,
        CFG_DLIM = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CALC,
        ST_MUL_P,
        ST_MUL_D,
        ST_MUL_I,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_ADD,
        ST_FINISH,
        ST_REST
    } state_t;

    typedef struct packed {
        logic ld_sample;
        logic ld_diff;
        logic mul_p;
        logic mul_d;
        logic mul_i;
        logic div_start;
        logic ld_drive;
        logic ld_result;
        logic ld_rest;
    } ctl_t;

endpackage

@@ src/evp_div.sv @@
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
module evp_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [evp_pkg::DVD_W-1:0]    dividend,
    input  logic [evp_pkg::GAIN_W-1:0]   divisor,
    output logic                         done,
    output logic [evp_pkg::DVD_W-1:0]    quotient
);
    import evp_pkg::*;

    localparam int STEP_W = $clog2(DVD_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

    logic [DVD_W-1:0]  quo_reg;
    logic [GAIN_W-1:0] rem_reg;
    logic [GAIN_W-1:0] den_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [GAIN_W:0]   trial;
    logic [GAIN_W:0]   diff;
    logic              fits;

    // The dividend shifts out of the top of quo_reg while quotient bits enter at the bottom.
    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? diff[GAIN_W-1:0] : trial[GAIN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ src/encoder_velocity_pid.sv @@
// Encoder velocity PID: one item in, one item out. The sequencer steps CALC, MUL_P,
// MUL_D and MUL_I lead to DIV_START and the wait on the serial divider, then to ADD
// and FINISH. The next item is taken the cycle after the result appears; an at-rest
// item goes from CALC straight to REST and gives its result there.
// An item whose predecessor's result still waits holds in its last step until it leaves.
// Synchronous active-low reset loads the default gains and clears the controller state.
module encoder_velocity_pid (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [evp_pkg::CNT_W-1:0]  s_encoder_count,
    input  logic signed [evp_pkg::TGT_W-1:0]  s_target_rate,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [evp_pkg::DRV_W-1:0]  m_drive_value,
    output logic signed [evp_pkg::RATE_W-1:0] m_measured_rate,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [evp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [evp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import evp_pkg::*;
    `include "encoder_velocity_pid_macros.svh"

    state_t state_reg, state_next;
    ctl_t   ctl;

    logic [GAIN_W-1:0] kp_gain_reg, kd_gain_reg, ki_gain_reg, gain_divisor_reg;
    logic [ILIM_W-1:0] integral_limit_reg;
    logic [DLIM_W-1:0] drive_limit_reg;

    logic [CNT_W-1:0]         last_count_reg;
    logic signed [RATE_W-1:0] last_rate_reg;
    logic signed [DRV_W-1:0]  last_drive_reg;
    logic signed [INT_W-1:0]  integral_reg;

    logic signed [RATE_W-1:0] rate_reg;
    logic signed [TGT_W-1:0]  target_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [ERR_W-1:0]  drate_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     neg_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [DSUM_W-1:0] drive_reg;

    logic                     m_valid_reg;
    logic signed [DRV_W-1:0]  m_drive_reg;
    logic signed [RATE_W-1:0] m_rate_reg;

    logic                     out_free;
    logic [GAIN_W-1:0]        mul_gain;
    logic signed [ERR_W-1:0]  mul_opnd;
    logic signed [PROD_W-1:0] mul_prod;
    logic [GAIN_W-1:0]        div_den;
    logic [DVD_W-1:0]         div_dvd;
    logic                     div_done;
    logic [DVD_W-1:0]         div_quo;
    logic signed [DSUM_W-1:0] delta;
    logic signed [DSUM_W-1:0] lim_ext;
    logic signed [ACC_W-1:0]  cap_ext;
    logic signed [DRV_W-1:0]  lim_s;
    logic signed [DRV_W-1:0]  drive_sat;
    logic signed [ACC_W-1:0]  acc_clamp;
    logic                     at_rest;

    assign s_ready         = (state_reg == ST_IDLE);
    // Gains change only between items, never under a computation or a waiting result.
    assign cfg_ready       = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid         = m_valid_reg;
    assign m_drive_value   = m_drive_reg;
    assign m_measured_rate = m_rate_reg;
    assign out_free        = !m_valid_reg || m_ready;
    assign at_rest         = (target_reg == '0) && (rate_reg == '0);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_gain_reg        <= KP_RESET;
            kd_gain_reg        <= KD_RESET;
            ki_gain_reg        <= KI_RESET;
            gain_divisor_reg   <= DIV_RESET;
            integral_limit_reg <= ILIM_RESET;
            drive_limit_reg    <= DLIM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                CFG_KP:   kp_gain_reg        <= cfg_data[GAIN_W-1:0];
                CFG_KD:   kd_gain_reg        <= cfg_data[GAIN_W-1:0];
                CFG_KI:   ki_gain_reg        <= cfg_data[GAIN_W-1:0];
                CFG_DIV:  gain_divisor_reg   <= cfg_data[GAIN_W-1:0];
                CFG_ILIM: integral_limit_reg <= cfg_data[ILIM_W-1:0];
                CFG_DLIM: drive_limit_reg    <= cfg_data[DLIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_valid) state_next = ST_CALC;
            ST_CALC:      state_next = at_rest ? ST_REST : ST_MUL_P;
            ST_MUL_P:     state_next = ST_MUL_D;
            ST_MUL_D:     state_next = ST_MUL_I;
            ST_MUL_I:     state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:  if (div_done) state_next = ST_ADD;
            ST_ADD:       state_next = ST_FINISH;
            ST_FINISH:    if (out_free) state_next = ST_IDLE;
            ST_REST:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        unique case (state_reg)
            ST_IDLE:      ctl.ld_sample = s_valid;
            ST_CALC:      ctl.ld_diff   = 1'b1;
            ST_MUL_P:     ctl.mul_p     = 1'b1;
            ST_MUL_D:     ctl.mul_d     = 1'b1;
            ST_MUL_I:     ctl.mul_i     = 1'b1;
            ST_DIV_START: ctl.div_start = 1'b1;
            ST_DIV_WAIT:  ctl.ld_drive  = div_done;
            ST_ADD:       ;
            ST_FINISH:    ctl.ld_result = out_free;
            ST_REST:      ctl.ld_rest   = out_free;
            default:      ;
        endcase
    end

    // The one multiplier, shared by the three gain products.
    always_comb begin
        case (state_reg)
            ST_MUL_D: begin
                mul_gain = kd_gain_reg;
                mul_opnd = drate_reg;
            end
            ST_MUL_I: begin
                mul_gain = ki_gain_reg;
                mul_opnd = err_reg;
            end
            default: begin
                mul_gain = kp_gain_reg;
                mul_opnd = err_reg;
            end
        endcase
    end

    assign mul_prod = PROD_W'($signed({1'b0, mul_gain}) * mul_opnd);

    // Division truncates toward zero, so divide the magnitude and restore the sign.
    assign div_den = (gain_divisor_reg == '0) ? GAIN_W'(1) : gain_divisor_reg;
    assign div_dvd = DVD_W'(sum_reg[SUM_W-1] ? -sum_reg : sum_reg);

    evp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctl.div_start),
        .dividend (div_dvd),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign delta   = neg_reg ? -DSUM_W'(div_quo) : DSUM_W'(div_quo);
    assign lim_ext = DSUM_W'($signed({1'b0, drive_limit_reg}));
    assign cap_ext = ACC_W'($signed({1'b0, integral_limit_reg}));
    assign lim_s   = $signed({1'b0, drive_limit_reg});

    always_comb begin
        if (acc_reg > cap_ext) begin
            acc_clamp = cap_ext;
        end else if (acc_reg < -cap_ext) begin
            acc_clamp = -cap_ext;
        end else begin
            acc_clamp = acc_reg;
        end
        drive_sat = drive_reg[DRV_W-1:0];
        if (drive_reg >= lim_ext) begin
            drive_sat = lim_s;
        end else if (drive_reg <= -lim_ext) begin
            drive_sat = -lim_s;
        end
    end

    // Controller state, cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_count_reg <= '0;
            last_rate_reg  <= '0;
            last_drive_reg <= '0;
            integral_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (ctl.ld_result || ctl.ld_rest) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (ctl.ld_sample) begin
                last_count_reg <= s_encoder_count;
            end
            if (ctl.ld_result) begin
                last_drive_reg <= drive_sat;
                last_rate_reg  <= rate_reg;
                // Hitting either drive limit empties the integral.
                if (drive_reg >= lim_ext || drive_reg <= -lim_ext) begin
                    integral_reg <= '0;
                end else begin
                    integral_reg <= INT_W'(acc_clamp);
                end
            end
            if (ctl.ld_rest) begin
                last_drive_reg <= '0;
                last_rate_reg  <= '0;
                integral_reg   <= '0;
            end
        end
    end

    // Working registers of the current item.
    always_ff @(posedge aclk) begin
        if (ctl.ld_sample) begin
            rate_reg   <= s_encoder_count - last_count_reg;
            target_reg <= s_target_rate;
        end
        if (ctl.ld_diff) begin
            err_reg   <= ERR_W'(target_reg) - ERR_W'(rate_reg);
            drate_reg <= ERR_W'(rate_reg) - ERR_W'(last_rate_reg);
        end
        if (ctl.mul_p || ctl.mul_d || ctl.mul_i) begin
            prod_reg <= mul_prod;
        end
        if (ctl.mul_p) begin
            sum_reg <= SUM_W'(integral_reg);
        end
        if (ctl.mul_d || ctl.mul_i) begin
            sum_reg <= sum_reg + SUM_W'(prod_reg);
        end
        if (ctl.div_start) begin
            neg_reg <= sum_reg[SUM_W-1];
            acc_reg <= ACC_W'(integral_reg) + ACC_W'(prod_reg);
        end
        if (ctl.ld_drive) begin
            drive_reg <= DSUM_W'(last_drive_reg) + delta;
        end
        if (ctl.ld_result) begin
            m_drive_reg <= drive_sat;
            m_rate_reg  <= rate_reg;
        end
        if (ctl.ld_rest) begin
            m_drive_reg <= '0;
            m_rate_reg  <= '0;
        end
    end

    `EVP_ASSERT_IMPLY(a_drive_in_range, m_valid_reg,
        (m_drive_reg <= lim_s) && (m_drive_reg >= -lim_s), "drive beyond its limit")
    `EVP_ASSERT_IMPLY(a_div_done_in_wait, div_done,
        state_reg == ST_DIV_WAIT, "divider finished outside the wait step")
    `EVP_ASSERT_IMPLY(a_result_matches_state, m_valid_reg,
        m_drive_reg == last_drive_reg, "pending drive differs from stored drive")
    `EVP_ASSERT_ALWAYS(a_ready_only_idle,
        !s_ready || (state_reg == ST_IDLE), "item taken while busy")

endmodule
